@@ design/ssj_pkg.sv @@
`default_nettype none
package ssj_pkg;

  // Store geometry and key width.
  localparam int STORE_DEPTH = 4096;
  localparam int KEY_W       = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // Result field widths.
  localparam int UNI_W  = CNT_W + 1;
  localparam int Q_FRAC = 16;
  localparam int JAC_W  = Q_FRAC + 1;

  // Configuration port.
  localparam int THR_W      = 17;
  localparam int MEMBER_W   = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;

  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(65536);
  localparam logic [MEMBER_W-1:0] MEMBER_RESET = MEMBER_W'(1048576);

  // Value-id class limits.
  localparam logic [MEMBER_W-1:0] ID8_LIMIT  = MEMBER_W'(255);
  localparam logic [MEMBER_W-1:0] ID16_LIMIT = MEMBER_W'(65535);

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_CHECK_GROW  = 2'd1,
    CFG_SMALLEST    = 2'd2
  } cfg_idx_t;

  // Request operations.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ design/ssj_in_if.sv @@
`default_nettype none
interface ssj_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ssj_pkg::KEY_W-1:0] key;
  logic              last;

  modport source (output valid, output op, output key, output last, input ready);
  modport sink   (input valid, input op, input key, input last, output ready);
endinterface
`default_nettype wire

@@ design/ssj_out_if.sv @@
`default_nettype none
interface ssj_out_if;
  logic                       valid;
  logic                       ready;
  logic [ssj_pkg::CNT_W-1:0]  intersection_count;
  logic [ssj_pkg::UNI_W-1:0]  union_count;
  logic [ssj_pkg::JAC_W-1:0]  jaccard_q16;
  logic                       merge;
  logic                       width_grows;
  logic                       overflowed;

  modport source (output valid, output intersection_count, output union_count,
                  output jaccard_q16, output merge, output width_grows,
                  output overflowed, input ready);
  modport sink   (input valid, input intersection_count, input union_count,
                  input jaccard_q16, input merge, input width_grows,
                  input overflowed, output ready);
endinterface
`default_nettype wire

@@ design/ssj_ram.sv @@
`default_nettype none
module ssj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/sorted_set_jaccard_merge_decision_unit.sv @@
// Sorted-set intersection with Jaccard merge decision.
// The in_ch channel carries requests: op clear empties the reference store,
// op load appends one key to it, op probe looks one key of the second set up.
// Keys of each set arrive ascending. A probe with last set produces one result
// on out_ch: intersection, union, Jaccard index in Q1.16 and the merge flags.
// Clear and load complete as they are accepted. A probe reads and compares
// each stored key that the walk pointer examines (one read of the store, one
// compare). The final probe adds a setup step, the steps of the restoring
// divider and a load of the output register. in_ch.ready is low while an
// item is in progress. A finished result sits in the output register while
// new requests are taken; a later result waits until out_ch.ready drains the
// earlier one. Reset empties the reference and restores the register
// defaults; the store contents need no clearing. The cfg port writes one
// register per cycle with no stall and is meant to be used while the block
// is idle.
`default_nettype none
module sorted_set_jaccard_merge_decision_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  ssj_in_if.sink                         in_ch,
  ssj_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire  [ssj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ssj_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssj_pkg::*;

  localparam int STEP_W = $clog2(JAC_W);
  localparam int REM_W  = UNI_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(STORE_DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(JAC_W - 1);

  // Control registers.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  ref_cnt_r, ref_cnt_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic [CNT_W-1:0]  probe_cnt_r, probe_cnt_nxt;
  logic [CNT_W-1:0]  match_r, match_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [THR_W-1:0]  thr_r;
  logic              chk_r;
  logic [MEMBER_W-1:0] smallest_r;

  // Payload registers.
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              last_r, last_nxt;
  logic [UNI_W-1:0]  uni_r, uni_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [JAC_W-1:0]  quot_r, quot_nxt;
  logic [CNT_W-1:0]  o_inter_r, o_inter_nxt;
  logic [UNI_W-1:0]  o_uni_r, o_uni_nxt;
  logic [JAC_W-1:0]  o_jac_r, o_jac_nxt;
  logic              o_merge_r, o_merge_nxt;
  logic              o_grows_r, o_grows_nxt;
  logic              o_ovf_r, o_ovf_nxt;

  // Store ports.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0]  ram_wdata, ram_rdata;

  // Helpers.
  logic              in_fire;
  logic [CNT_W-1:0]  walk_inc;
  logic [REM_W-1:0]  trial;
  logic              qbit;
  logic [JAC_W-1:0]  jac;
  logic              grows;
  logic              finish_last;

  function automatic logic class_grows(input logic [MEMBER_W-1:0] shared_size,
                                       input logic [MEMBER_W-1:0] member_size);
    logic g;
    g = 1'b0;
    if (member_size <= ID8_LIMIT && shared_size > ID8_LIMIT) begin
      g = 1'b1;
    end
    if (member_size <= ID16_LIMIT && shared_size > ID16_LIMIT) begin
      g = 1'b1;
    end
    return g;
  endfunction

  ssj_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign walk_inc = walk_r + CNT_W'(1);

  // One restoring divider step; the first step takes the integer bit.
  always_comb begin
    trial = (step_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    qbit  = (trial >= REM_W'(uni_r));
    if (qbit) begin
      trial = trial - REM_W'(uni_r);
    end
  end

  // Final result fields.
  assign jac = (uni_r == '0) ? '0 : quot_r;
  assign grows = class_grows(MEMBER_W'(uni_r), MEMBER_W'(probe_cnt_r)) ||
                 class_grows(MEMBER_W'(uni_r), smallest_r);

  // Sequencer: next state, datapath updates and store control.
  always_comb begin
    state_nxt     = state_r;
    ref_cnt_nxt   = ref_cnt_r;
    walk_nxt      = walk_r;
    probe_cnt_nxt = probe_cnt_r;
    match_nxt     = match_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    uni_nxt       = uni_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    o_inter_nxt   = o_inter_r;
    o_uni_nxt     = o_uni_r;
    o_jac_nxt     = o_jac_r;
    o_merge_nxt   = o_merge_r;
    o_grows_nxt   = o_grows_r;
    o_ovf_nxt     = o_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = ref_cnt_r[ADDR_W-1:0];
    ram_wdata     = in_ch.key;
    ram_re        = 1'b0;
    ram_raddr     = walk_r[ADDR_W-1:0];
    in_ch.ready   = (state_r == S_IDLE);
    finish_last   = last_r;

    // The receiver drains the output register.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.op)
            OP_CLEAR: begin
              ref_cnt_nxt   = '0;
              walk_nxt      = '0;
              probe_cnt_nxt = '0;
              match_nxt     = '0;
              ovf_nxt       = 1'b0;
            end
            OP_LOAD: begin
              if (ref_cnt_r == DEPTH_CNT) begin
                ovf_nxt = 1'b1;
              end else begin
                ram_we      = 1'b1;
                ref_cnt_nxt = ref_cnt_r + CNT_W'(1);
              end
            end
            OP_PROBE: begin
              key_nxt  = in_ch.key;
              last_nxt = in_ch.last;
              if (probe_cnt_r == DEPTH_CNT) begin
                ovf_nxt = 1'b1;
                if (in_ch.last) begin
                  state_nxt = S_PREP;
                end
              end else begin
                probe_cnt_nxt = probe_cnt_r + CNT_W'(1);
                if (walk_r < ref_cnt_r) begin
                  state_nxt = S_READ;
                end else if (in_ch.last) begin
                  state_nxt = S_PREP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_CMP;
      end

      // Merge-join step: skip smaller stored keys, count an exact hit.
      S_CMP: begin
        if (ram_rdata < key_r) begin
          walk_nxt = walk_inc;
          if (walk_inc < ref_cnt_r) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = finish_last ? S_PREP : S_IDLE;
          end
        end else begin
          if (ram_rdata == key_r) begin
            walk_nxt  = walk_inc;
            match_nxt = match_r + CNT_W'(1);
          end
          state_nxt = finish_last ? S_PREP : S_IDLE;
        end
      end

      S_PREP: begin
        uni_nxt   = UNI_W'(ref_cnt_r) + UNI_W'(probe_cnt_r) - UNI_W'(match_r);
        rem_nxt   = REM_W'(match_r);
        quot_nxt  = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[JAC_W-2:0], qbit};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end

      // Load the output register once it is free, then rewind the probe side.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          o_inter_nxt   = match_r;
          o_uni_nxt     = uni_r;
          o_jac_nxt     = jac;
          o_grows_nxt   = grows;
          o_merge_nxt   = (uni_r != '0) && (jac >= thr_r) && !(chk_r && grows);
          o_ovf_nxt     = ovf_r;
          out_valid_nxt = 1'b1;
          walk_nxt      = '0;
          probe_cnt_nxt = '0;
          match_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_cnt_r   <= '0;
      walk_r      <= '0;
      probe_cnt_r <= '0;
      match_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ref_cnt_r   <= ref_cnt_nxt;
      walk_r      <= walk_nxt;
      probe_cnt_r <= probe_cnt_nxt;
      match_r     <= match_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      chk_r      <= 1'b0;
      smallest_r <= MEMBER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:  thr_r      <= cfg_data[THR_W-1:0];
        CFG_CHECK_GROW: chk_r      <= cfg_data[0];
        CFG_SMALLEST:   smallest_r <= cfg_data[MEMBER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    last_r    <= last_nxt;
    uni_r     <= uni_nxt;
    rem_r     <= rem_nxt;
    quot_r    <= quot_nxt;
    o_inter_r <= o_inter_nxt;
    o_uni_r   <= o_uni_nxt;
    o_jac_r   <= o_jac_nxt;
    o_merge_r <= o_merge_nxt;
    o_grows_r <= o_grows_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.intersection_count = o_inter_r;
  assign out_ch.union_count        = o_uni_r;
  assign out_ch.jaccard_q16        = o_jac_r;
  assign out_ch.merge              = o_merge_r;
  assign out_ch.width_grows        = o_grows_r;
  assign out_ch.overflowed         = o_ovf_r;

  // The walk pointer never passes the loaded reference.
  assert property (@(posedge clk) disable iff (!rst_n) walk_r <= ref_cnt_r)
    else $error("walk pointer beyond reference count");

  // Every hit consumed a counted probe.
  assert property (@(posedge clk) disable iff (!rst_n) match_r <= probe_cnt_r)
    else $error("match count exceeds probe count");

  // The reference count stays within the store.
  assert property (@(posedge clk) disable iff (!rst_n) ref_cnt_r <= DEPTH_CNT)
    else $error("reference count beyond store depth");

  // Each store read is followed by its compare.
  assert property (@(posedge clk) disable iff (!rst_n) ram_re |=> state_r == S_CMP)
    else $error("store read not followed by compare");

  // A result appears only out of the final state of a probe set.
  assert property (@(posedge clk) disable iff (!rst_n)
                   $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside result state");

endmodule
`default_nettype wire
